### rtl/bmv_pkg.sv
// Shared types and constants for the block mean / variance accumulator.
package bmv_pkg;

    localparam int SAMPLE_W    = 17;
    localparam int RAW_W       = 32;
    localparam int VALUE_W     = 50;
    localparam int NUM_W       = 128;
    localparam int DCNT_W      = $clog2(NUM_W);
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 21;

    localparam logic [CFG_INDEX_W-1:0] CFG_STAT_MODE    = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_LENGTH = 1'd1;

    localparam logic                  STAT_MODE_MEAN   = 1'b0;
    localparam logic                  STAT_MODE_RST    = 1'b1;
    localparam logic [CFG_DATA_W-1:0] BLOCK_LENGTH_RST = 21'd1000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQN,
        ST_NSQ,
        ST_MAG,
        ST_DIV,
        ST_RCMP,
        ST_RINC,
        ST_OUT
    } bmv_state_t;

    typedef struct packed {
        logic [NUM_W-1:0] a;
        logic [NUM_W-1:0] b;
        logic             sub;
    } alu_req_t;

    typedef struct packed {
        logic [NUM_W-1:0] result;
        logic             carry;
    } alu_rsp_t;

endpackage

### rtl/bmv_alu.sv
// Shared wide adder / subtractor used for multiply, divide, rounding and negation.
module bmv_alu
    import bmv_pkg::*;
(
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    logic [NUM_W:0] sum;
    logic [NUM_W-1:0] b_op;

    assign b_op = req.sub ? ~req.b : req.b;
    // carry out on a subtract means a >= b
    assign sum = {1'b0, req.a} + {1'b0, b_op} + (NUM_W+1)'(req.sub);

    assign rsp.result = sum[NUM_W-1:0];
    assign rsp.carry  = sum[NUM_W];

endmodule

### rtl/block_mean_variance.sv
// Block mean / variance: a word that does not end a block is accumulated and the block stays ready.
// A block-ending word runs a shift-add multiply / restoring divide on one shared adder:
// mean: restoring divide of |sum| << FRACTION_BITS by N, then round half up, then negate if negative.
// variance: N*N and N*sumsq - |sum|^2, then the divide of the latter by N*N, then round half up;
// in_ready stays low until the result word leaves.
// Reset: stat_mode = variance, block_length = 1000, accumulators cleared; no clearing pass.
module block_mean_variance
    import bmv_pkg::*;
#(
    parameter int MAX_BLOCK_LENGTH = 1048576,
    parameter int FRACTION_BITS    = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [RAW_W-1:0]       raw_word,
    input  logic                   stream_end,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [VALUE_W-1:0]     stat_value,
    output logic                   partial_block,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int CNT_W = $clog2(MAX_BLOCK_LENGTH + 1);
    localparam int SUM_W = SAMPLE_W + CNT_W;
    localparam int SQ_W  = 32 + CNT_W;
    localparam int D_W   = 2 * CNT_W;

    bmv_state_t state_reg, state_next;

    logic                  stat_mode_reg, stat_mode_next;
    logic [CFG_DATA_W-1:0] block_length_reg, block_length_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [SQ_W-1:0]       sumsq_reg, sumsq_next;

    logic [CNT_W-1:0]      n_reg, n_next;
    logic [SUM_W-1:0]      mag_reg, mag_next;
    logic [SQ_W-1:0]       sq_reg, sq_next;
    logic                  mode_reg, mode_next;
    logic                  neg_reg, neg_next;
    logic                  partial_reg, partial_next;
    logic [NUM_W-1:0]      acc_reg, acc_next;
    logic [NUM_W-1:0]      mcand_reg, mcand_next;
    logic [SUM_W-1:0]      mplier_reg, mplier_next;
    logic [D_W-1:0]        d_reg, d_next;
    logic [D_W-1:0]        rem_reg, rem_next;
    logic [VALUE_W-1:0]    q_reg, q_next;
    logic                  round_reg, round_next;
    logic [DCNT_W-1:0]     dcnt_reg, dcnt_next;

    alu_req_t alu_req;
    alu_rsp_t alu_rsp;

    logic signed [SAMPLE_W-1:0]   sample;
    logic signed [2*SAMPLE_W-1:0] sample_sq;
    logic signed [SUM_W-1:0]      sum_add;
    logic [SQ_W-1:0]              sumsq_add;
    logic [CNT_W-1:0]             count_inc;
    logic [SUM_W-1:0]             mag_add;
    logic [31:0]                  bl_ext;
    logic [CNT_W-1:0]             n_eff;
    logic                         block_full;
    logic [D_W:0]                 rem_shift;

    bmv_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    assign sample    = $signed(raw_word[SAMPLE_W-1:0]);
    assign sample_sq = sample * sample;
    assign sum_add   = sum_reg + SUM_W'(sample);
    assign sumsq_add = sumsq_reg + SQ_W'($unsigned(sample_sq));
    assign count_inc = count_reg + 1'b1;
    assign mag_add   = sum_add[SUM_W-1] ? ($unsigned(~sum_add) + 1'b1) : $unsigned(sum_add);

    // zero length acts as 1, oversize lengths saturate
    assign bl_ext = 32'(block_length_reg);
    always_comb
    begin
        if (bl_ext == 32'd0)
            n_eff = CNT_W'(1);
        else if (bl_ext > 32'(MAX_BLOCK_LENGTH))
            n_eff = CNT_W'(MAX_BLOCK_LENGTH);
        else
            n_eff = bl_ext[CNT_W-1:0];
    end

    assign block_full = (count_inc >= n_eff);
    assign rem_shift  = {rem_reg, acc_reg[NUM_W-1]};

    assign cfg_ready     = 1'b1;
    assign stat_value    = q_reg;
    assign partial_block = partial_reg;

    always_comb
    begin
        state_next        = state_reg;
        stat_mode_next    = stat_mode_reg;
        block_length_next = block_length_reg;
        count_next        = count_reg;
        sum_next          = sum_reg;
        sumsq_next        = sumsq_reg;
        n_next            = n_reg;
        mag_next          = mag_reg;
        sq_next           = sq_reg;
        mode_next         = mode_reg;
        neg_next          = neg_reg;
        partial_next      = partial_reg;
        acc_next          = acc_reg;
        mcand_next        = mcand_reg;
        mplier_next       = mplier_reg;
        d_next            = d_reg;
        rem_next          = rem_reg;
        q_next            = q_reg;
        round_next        = round_reg;
        dcnt_next         = dcnt_reg;
        in_ready          = 1'b0;
        out_valid         = 1'b0;
        alu_req.a         = acc_reg;
        alu_req.b         = mcand_reg;
        alu_req.sub       = 1'b0;

        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_STAT_MODE:    stat_mode_next    = cfg_data[0];
                CFG_BLOCK_LENGTH: block_length_next = cfg_data;
                default:          ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    count_next = count_inc;
                    sum_next   = sum_add;
                    sumsq_next = sumsq_add;
                    if (block_full || stream_end)
                    begin
                        count_next   = '0;
                        sum_next     = '0;
                        sumsq_next   = '0;
                        n_next       = n_eff;
                        mag_next     = mag_add;
                        sq_next      = sumsq_add;
                        mode_next    = stat_mode_reg;
                        neg_next     = sum_add[SUM_W-1];
                        partial_next = !block_full;
                        if (stat_mode_reg == STAT_MODE_MEAN)
                        begin
                            acc_next   = NUM_W'(mag_add) << FRACTION_BITS;
                            d_next     = D_W'(n_eff);
                            rem_next   = '0;
                            dcnt_next  = '0;
                            state_next = ST_DIV;
                        end
                        else
                        begin
                            acc_next    = '0;
                            mcand_next  = NUM_W'(n_eff);
                            mplier_next = SUM_W'(n_eff);
                            state_next  = ST_SQN;
                        end
                    end
                end
            end

            // N*N, then N*sumsq, then minus |sum|^2: shift-add over the multiplier bits
            ST_SQN, ST_NSQ, ST_MAG:
            begin
                alu_req.sub = (state_reg == ST_MAG);
                if (mplier_reg == '0)
                begin
                    case (state_reg)
                        ST_SQN:
                        begin
                            d_next      = acc_reg[D_W-1:0];
                            acc_next    = '0;
                            mcand_next  = NUM_W'(sq_reg);
                            mplier_next = SUM_W'(n_reg);
                            state_next  = ST_NSQ;
                        end
                        ST_NSQ:
                        begin
                            mcand_next  = NUM_W'(mag_reg);
                            mplier_next = mag_reg;
                            state_next  = ST_MAG;
                        end
                        default:
                        begin
                            acc_next   = acc_reg << FRACTION_BITS;
                            rem_next   = '0;
                            dcnt_next  = '0;
                            state_next = ST_DIV;
                        end
                    endcase
                end
                else
                begin
                    if (mplier_reg[0])
                        acc_next = alu_rsp.result;
                    mcand_next  = mcand_reg << 1;
                    mplier_next = mplier_reg >> 1;
                end
            end

            // restoring divide, one numerator bit per cycle
            ST_DIV:
            begin
                alu_req.a   = NUM_W'(rem_shift);
                alu_req.b   = NUM_W'(d_reg);
                alu_req.sub = 1'b1;
                rem_next    = alu_rsp.carry ? alu_rsp.result[D_W-1:0] : rem_shift[D_W-1:0];
                q_next      = {q_reg[VALUE_W-2:0], alu_rsp.carry};
                acc_next    = acc_reg << 1;
                dcnt_next   = dcnt_reg + 1'b1;
                if (dcnt_reg == DCNT_W'(NUM_W - 1))
                    state_next = ST_RCMP;
            end

            // round half up: 2*rem >= d
            ST_RCMP:
            begin
                alu_req.a   = NUM_W'({rem_reg, 1'b0});
                alu_req.b   = NUM_W'(d_reg);
                alu_req.sub = 1'b1;
                round_next  = alu_rsp.carry;
                state_next  = ST_RINC;
            end

            // add the rounding bit, then negate a negative mean on a separate pass
            ST_RINC:
            begin
                if (round_reg)
                begin
                    alu_req.a  = NUM_W'(q_reg);
                    alu_req.b  = NUM_W'(1'b1);
                    q_next     = alu_rsp.result[VALUE_W-1:0];
                    round_next = 1'b0;
                end
                else if (mode_reg == STAT_MODE_MEAN && neg_reg)
                begin
                    alu_req.a   = '0;
                    alu_req.b   = NUM_W'(q_reg);
                    alu_req.sub = 1'b1;
                    q_next      = alu_rsp.result[VALUE_W-1:0];
                    neg_next    = 1'b0;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end

            ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            stat_mode_reg    <= STAT_MODE_RST;
            block_length_reg <= BLOCK_LENGTH_RST;
            count_reg        <= '0;
            sum_reg          <= '0;
            sumsq_reg        <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            stat_mode_reg    <= stat_mode_next;
            block_length_reg <= block_length_next;
            count_reg        <= count_next;
            sum_reg          <= sum_next;
            sumsq_reg        <= sumsq_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg       <= n_next;
        mag_reg     <= mag_next;
        sq_reg      <= sq_next;
        mode_reg    <= mode_next;
        neg_reg     <= neg_next;
        partial_reg <= partial_next;
        acc_reg     <= acc_next;
        mcand_reg   <= mcand_next;
        mplier_reg  <= mplier_next;
        d_reg       <= d_next;
        rem_reg     <= rem_next;
        q_reg       <= q_next;
        round_reg   <= round_next;
        dcnt_reg    <= dcnt_next;
    end

endmodule

### rtl/bmv_checker.sv
// Port-level assertions for block_mean_variance and the bind that attaches them.
module bmv_checker
    import bmv_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_ready,
    input logic                   stream_end,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [VALUE_W-1:0]     stat_value,
    input logic                   partial_block
);

    // a result word holds until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(stat_value) && $stable(partial_block))
        else $error("result word changed while stalled");

    // one word in flight: no intake while a result waits
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken while result pending");

    // the final word always yields a result, so the block goes busy
    a_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && stream_end |=> !in_ready)
        else $error("stream end did not start a result");

    // after a result leaves the block takes input again
    a_back_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |=> in_ready && !out_valid)
        else $error("block not idle after result taken");

endmodule

bind block_mean_variance bmv_checker u_bmv_checker (.*);
